// ===== src/rdnr_pkg.sv =====
// ----------------------------------------------------------------------------
// rdnr_pkg: shared types and constants of the rotation delay network reverb
// Register indexes, reset values, field widths and the multiplier control struct.
// ----------------------------------------------------------------------------
package rdnr_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned COEF_BITS_DEF   = 16;
	localparam int unsigned LINE_DEPTH_DEF  = 16384;
	localparam int unsigned LINE_COUNT      = 7;
	localparam int unsigned LEN_BITS        = 14;
	localparam int unsigned REG_COUNT       = 8;
	localparam int unsigned REG_BITS        = 64;
	localparam int unsigned IDX_BITS        = 3;
	localparam int unsigned SHIFT_BITS      = 6;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_FRONT_A = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_FRONT_B = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_OUT     = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_ROW0    = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_ROW1    = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_ROW2    = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_FLEN    = 3'd6;
	localparam logic [IDX_BITS-1:0] REG_BLEN    = 3'd7;

	localparam logic [63:0] RST_FRONT_A = 64'd140733193420799;
	localparam logic [63:0] RST_FRONT_B = 64'd140733193420799;
	localparam logic [63:0] RST_OUT     = 64'd28149215690751;
	localparam logic [47:0] RST_ROW0    = 48'd20613381046272;
	localparam logic [47:0] RST_ROW1    = 48'd120126254858240;
	localparam logic [47:0] RST_ROW2    = 48'd70371965426306;
	localparam logic [55:0] RST_FLEN    = 56'd4398314962945;
	localparam logic [41:0] RST_BLEN    = 42'd268451841;

	// control and status of the serial multiplier
	typedef struct packed {
		logic start;
		logic busy;
	} mul_ctl_t;

endpackage

// ===== src/rdnr_mul.sv =====
// ----------------------------------------------------------------------------
// rdnr_mul: bit-serial signed multiplier with Q1.x rounding
// Shift-add, one coefficient bit per cycle.
// ----------------------------------------------------------------------------
module rdnr_mul #(
	parameter int unsigned SAMPLE_BITS = rdnr_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COEF_BITS   = rdnr_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COEF_BITS-1:0]   coef,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	output rdnr_pkg::mul_ctl_t            ctl,
	output logic signed [SAMPLE_BITS:0]   prod
);
	localparam int unsigned PW = SAMPLE_BITS + COEF_BITS;
	localparam int unsigned CW = $clog2(COEF_BITS + 1);

	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic [COEF_BITS-1:0]   cf_q;
	logic signed [PW-1:0]   acc_q;
	logic signed [PW-1:0]   mc_q;
	logic signed [PW-1:0]   term;
	logic signed [PW-1:0]   rnd_sum;

	// partial product of this step; top coefficient bit has negative weight
	always_comb begin
		term = cf_q[0] ? mc_q : '0;
		if (cnt_q == CW'(COEF_BITS - 1))
			term = -term;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(COEF_BITS - 1))
				busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			cf_q  <= coef;
			mc_q  <= PW'(smp);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + term;
			mc_q  <= mc_q <<< 1;
			cf_q  <= cf_q >> 1;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;

	// round half up then floor shift; result fits in SAMPLE_BITS+1
	assign rnd_sum = acc_q + (PW'(1) <<< (COEF_BITS - 2));
	assign prod    = rnd_sum[PW-1 -: SAMPLE_BITS+1];
endmodule

// ===== src/rotation_delay_network_reverb_top.sv =====
// ----------------------------------------------------------------------------
// rotation_delay_network_reverb_top: four-stage rotation and feedback reverb
// Sequencer over one bit-serial multiplier and a single delay memory.
// ----------------------------------------------------------------------------
// Each transaction takes 36 products on the shared serial multiplier, plus
// memory and output steps. One transaction is in flight at a time; the next
// input is taken the cycle after the result is accepted. Throughput is set
// by the shared serial multiplier.
// Reset: arst_n clears control and positions; the delay memory is then swept
// to zero, one word a cycle, all LINE_COUNT*LINE_DEPTH words, before s_tready.
module rotation_delay_network_reverb_top #(
	parameter int unsigned LINE_DEPTH  = rdnr_pkg::LINE_DEPTH_DEF,
	parameter int unsigned SAMPLE_BITS = rdnr_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned COEF_BITS   = rdnr_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rdnr_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [rdnr_pkg::REG_BITS-1:0] cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// left_in [SAMPLE_BITS-1:0], right_in above
	input  logic [2*SAMPLE_BITS-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// left_out [SAMPLE_BITS-1:0], right_out above
	output logic [2*SAMPLE_BITS-1:0]      m_tdata
);
	localparam int unsigned SB   = SAMPLE_BITS;
	localparam int unsigned CB   = COEF_BITS;
	localparam int unsigned LC   = rdnr_pkg::LINE_COUNT;
	localparam int unsigned PB   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int unsigned LB   = $clog2(LC);
	localparam int unsigned AB   = LB + PB;
	localparam int unsigned LNB  = rdnr_pkg::LEN_BITS;
	localparam int unsigned PW   = (PB > LNB ? PB : LNB) + 1;
	localparam int unsigned MEMN = LC * LINE_DEPTH;
	localparam int unsigned AW   = SB + 3;
	localparam int unsigned CLRB = $clog2(MEMN + 1);

	// sequencer states
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_WAIT  = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_MWR   = 4'd5;
	localparam logic [3:0] ST_MRD   = 4'd6;
	localparam logic [3:0] ST_MRDW  = 4'd7;
	localparam logic [3:0] ST_MRDL  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	// operation steps (products and memory actions in order)
	localparam logic [5:0] OP_FRONT = 6'd0;   // 4 stages x 6 steps
	localparam logic [5:0] OP_TAP   = 6'd24;  // 3 taps x 2 steps
	localparam logic [5:0] OP_MAT   = 6'd30;  // 9 products
	localparam logic [5:0] OP_WB    = 6'd39;  // 3 writes
	localparam logic [5:0] OP_ORT   = 6'd42;  // 4 products
	localparam logic [5:0] OP_WET   = 6'd46;  // 4 products
	localparam logic [5:0] OP_END   = 6'd50;

	// configuration registers
	logic [63:0] front_a_q, front_b_q, out_q;
	logic [47:0] row0_q, row1_q, row2_q;
	logic [55:0] flen_q;
	logic [41:0] blen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_a_q <= rdnr_pkg::RST_FRONT_A;
			front_b_q <= rdnr_pkg::RST_FRONT_B;
			out_q     <= rdnr_pkg::RST_OUT;
			row0_q    <= rdnr_pkg::RST_ROW0;
			row1_q    <= rdnr_pkg::RST_ROW1;
			row2_q    <= rdnr_pkg::RST_ROW2;
			flen_q    <= rdnr_pkg::RST_FLEN;
			blen_q    <= rdnr_pkg::RST_BLEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rdnr_pkg::REG_FRONT_A: front_a_q <= cfg_data;
				rdnr_pkg::REG_FRONT_B: front_b_q <= cfg_data;
				rdnr_pkg::REG_OUT:     out_q     <= cfg_data;
				rdnr_pkg::REG_ROW0:    row0_q    <= cfg_data[47:0];
				rdnr_pkg::REG_ROW1:    row1_q    <= cfg_data[47:0];
				rdnr_pkg::REG_ROW2:    row2_q    <= cfg_data[47:0];
				rdnr_pkg::REG_FLEN:    flen_q    <= cfg_data[55:0];
				rdnr_pkg::REG_BLEN:    blen_q    <= cfg_data[41:0];
				default: ;
			endcase
		end
	end

	// coefficient k of a 64-bit register; zero beyond the register
	function automatic logic signed [CB-1:0] cf64(input logic [63:0] r, input int unsigned k);
		logic [127:0] w;
		w = {64'd0, r} >> (k * CB);
		return w[CB-1:0];
	endfunction

	function automatic logic signed [CB-1:0] cf48(input logic [47:0] r, input int unsigned k);
		logic [127:0] w;
		w = {80'd0, r} >> (k * CB);
		return w[CB-1:0];
	endfunction

	function automatic logic signed [SB-1:0] satf(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = AW'((1 << (SB - 1)) - 1);
		lo = -hi - AW'(1);
		if (v > hi) return hi[SB-1:0];
		if (v < lo) return lo[SB-1:0];
		return v[SB-1:0];
	endfunction

	// effective line length, zero as one, clipped to the depth
	function automatic logic [PW-1:0] eff_len(input logic [LNB-1:0] raw);
		logic [PW-1:0] v;
		v = PW'(raw);
		if (v == '0) v = PW'(1);
		if (v > PW'(LINE_DEPTH)) v = PW'(LINE_DEPTH);
		return v;
	endfunction

	// line lengths and positions
	logic [LNB-1:0] len_raw [LC];
	logic [PW-1:0]  len_e   [LC];
	always_comb begin
		for (int i = 0; i < 4; i++) len_raw[i] = flen_q[i*LNB +: LNB];
		for (int i = 0; i < 3; i++) len_raw[4+i] = blen_q[i*LNB +: LNB];
		for (int i = 0; i < LC; i++) len_e[i] = eff_len(len_raw[i]);
	end

	logic [LNB-1:0] pos_q [LC];

	function automatic logic [LNB-1:0] nxt(input logic [LNB-1:0] p, input logic [PW-1:0] len);
		logic [PW:0] s;
		s = (PW+1)'(p) + 1'b1;
		return (s >= (PW+1)'(len)) ? '0 : LNB'(p + 1'b1);
	endfunction

	// delay memory
	logic signed [SB-1:0] mem [MEMN];
	logic                 mwe;
	logic [AB-1:0]        maddr;
	logic signed [SB-1:0] mwd;
	logic signed [SB-1:0] mrd_q;

	always_ff @(posedge clk) begin
		if (mwe)
			mem[maddr] <= mwd;
		mrd_q <= mem[maddr];
	end

	function automatic logic [AB-1:0] addr_of(input int unsigned ln, input logic [LNB-1:0] p);
		logic [AB:0] a;
		a = (AB+1)'(ln) * (AB+1)'(LINE_DEPTH) + (AB+1)'(PB'(p));
		return a[AB-1:0];
	endfunction

	// serial multiplier
	logic                 mstart;
	logic signed [CB-1:0] mcoef;
	logic signed [SB-1:0] msmp;
	rdnr_pkg::mul_ctl_t   mctl;
	logic signed [SB:0]   mprod;

	rdnr_mul #(.SAMPLE_BITS(SB), .COEF_BITS(CB)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.coef   (mcoef),
		.smp    (msmp),
		.ctl    (mctl),
		.prod   (mprod)
	);

	// sequencer state
	logic [3:0]           state_q;
	logic [5:0]           op_q;
	logic [CLRB-1:0]      clr_q;
	logic signed [SB-1:0] dl_q, dr_q, l_q, r_q;
	logic signed [SB-1:0] fin_q [3];
	logic signed [AW-1:0] acc_q;
	logic signed [SB-1:0] t0_q;
	logic signed [SB-1:0] tap_q;
	logic signed [SB-1:0] fout_q [3];
	logic                 ovalid_q;
	logic [2*SB-1:0]      odata_q;

	// per step operand selection; stage found by range compares
	logic [2:0]           stg;
	logic [2:0]           sub;
	logic signed [CB-1:0] c_st, s_st;
	always_comb begin
		if (op_q < 6'd6)
			stg = 3'd0;
		else if (op_q < 6'd12)
			stg = 3'd1;
		else if (op_q < 6'd18)
			stg = 3'd2;
		else if (op_q < 6'd24)
			stg = 3'd3;
		else
			stg = 3'd4;
		sub  = 3'(op_q - 6'(stg) * 6'd6);
		c_st = '0;
		s_st = '0;
		case (stg)
			3'd0: begin c_st = cf64(front_a_q, 0); s_st = cf64(front_a_q, 1); end
			3'd1: begin c_st = cf64(front_a_q, 2); s_st = cf64(front_a_q, 3); end
			3'd2: begin c_st = cf64(front_b_q, 0); s_st = cf64(front_b_q, 1); end
			3'd3: begin c_st = cf64(front_b_q, 2); s_st = cf64(front_b_q, 3); end
			default: ;
		endcase
	end

	// matrix step: row and column of the product
	logic [3:0] k;
	logic [1:0] mr;
	logic [1:0] kc;
	logic signed [CB-1:0] mrow;
	always_comb begin
		k = 4'(op_q - OP_MAT);
		if (k < 4'd3)
			mr = 2'd0;
		else if (k < 4'd6)
			mr = 2'd1;
		else
			mr = 2'd2;
		kc   = 2'(k - 4'(mr) * 4'd3);
		mrow = '0;
		case (mr)
			2'd0: mrow = cf48(row0_q, int'(kc));
			2'd1: mrow = cf48(row1_q, int'(kc));
			default: mrow = cf48(row2_q, int'(kc));
		endcase
	end

	// operands of a product step; also tells whether it subtracts
	logic neg;
	always_comb begin
		neg    = 1'b0;
		mcoef  = '0;
		msmp   = '0;
		if (op_q < OP_TAP) begin
			case (sub)
				3'd0: begin mcoef = c_st; msmp = l_q; end
				3'd1: begin mcoef = s_st; msmp = r_q; neg = 1'b1; end
				3'd2: begin mcoef = s_st; msmp = l_q; end
				3'd3: begin mcoef = c_st; msmp = r_q; end
				default: ;
			endcase
		end else if (op_q < OP_MAT) begin
			mcoef  = cf64(out_q, 2);
			msmp   = tap_q;
		end else if (op_q < OP_WB) begin
			mcoef  = mrow;
			msmp   = fin_q[kc];
		end else if (op_q >= OP_ORT && op_q < OP_WET) begin
			case (op_q - OP_ORT)
				6'd0: begin mcoef = cf64(out_q, 0); msmp = fin_q[0]; end
				6'd1: begin mcoef = cf64(out_q, 1); msmp = fin_q[1]; neg = 1'b1; end
				6'd2: begin mcoef = cf64(out_q, 1); msmp = fin_q[0]; end
				default: begin mcoef = cf64(out_q, 0); msmp = fin_q[1]; end
			endcase
		end else if (op_q >= OP_WET && op_q < OP_END) begin
			mcoef  = cf64(out_q, 3);
			case (op_q - OP_WET)
				6'd0: msmp = l_q;
				6'd1: begin msmp = dl_q; neg = 1'b1; end
				6'd2: msmp = r_q;
				default: begin msmp = dr_q; neg = 1'b1; end
			endcase
		end
	end

	assign mstart = (state_q == ST_MUL);

	// memory address and write data; read address held until the data lands
	logic [1:0] tl;
	logic [2:0] tln;
	logic [1:0] wl;
	logic [2:0] wln;
	always_comb begin
		tl    = 2'((op_q - OP_TAP) >> 1);
		tln   = 3'd4 + {1'b0, tl};
		wl    = 2'(op_q - OP_WB);
		wln   = 3'd4 + {1'b0, wl};
		mwe   = 1'b0;
		maddr = '0;
		mwd   = '0;
		unique case (state_q) inside
			ST_CLEAR: begin
				mwe   = 1'b1;
				maddr = AB'(clr_q);
			end
			ST_MWR: begin
				mwe = 1'b1;
				if (op_q < OP_TAP) begin
					maddr = addr_of(int'(stg), pos_q[stg]);
					mwd   = r_q;
				end else begin
					maddr = addr_of(int'(wln), pos_q[wln]);
					mwd   = fout_q[wl];
				end
			end
			ST_MRD, ST_MRDW: begin
				if (op_q < OP_TAP)
					maddr = addr_of(int'(stg), nxt(pos_q[stg], len_e[stg]));
				else
					maddr = addr_of(int'(tln), nxt(pos_q[tln], len_e[tln]));
			end
			default: ;
		endcase
	end

	logic signed [AW-1:0] acc_nx;
	assign acc_nx = neg ? acc_q - AW'(mprod) : acc_q + AW'(mprod);

	assign s_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			op_q     <= '0;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < LC; i++) pos_q[i] <= '0;
		end else begin
			if (ovalid_q && m_tready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLRB'(MEMN - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q    <= OP_FRONT;
						acc_q   <= '0;
						l_q     <= s_tdata[SB-1:0];
						r_q     <= s_tdata[2*SB-1:SB];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_WAIT;
				ST_WAIT: if (!mctl.busy) state_q <= ST_ACC;
				ST_ACC: begin
					op_q    <= op_q + 1'b1;
					state_q <= ST_MUL;
					acc_q   <= acc_nx;
					if (op_q < OP_TAP) begin
						if (sub == 3'd1) begin
							t0_q  <= satf(acc_nx);
							acc_q <= '0;
						end else if (sub == 3'd3) begin
							l_q     <= t0_q;
							r_q     <= satf(acc_nx);
							acc_q   <= '0;
							state_q <= ST_MWR;
						end
					end else if (op_q < OP_MAT) begin
						fin_q[tl] <= satf(acc_nx + ((tl == 2'd0) ? AW'(l_q) :
						             (tl == 2'd1) ? AW'(r_q) : AW'(0)));
						acc_q <= '0;
						if (op_q + 1'b1 < OP_MAT) state_q <= ST_MRD;
					end else if (op_q < OP_WB) begin
						if (kc == 2'd2) begin
							fout_q[mr] <= satf(acc_nx);
							acc_q <= '0;
						end
						if (op_q + 1'b1 == OP_WB) state_q <= ST_MWR;
					end else if (op_q < OP_WET) begin
						if (op_q - OP_ORT == 6'd1) begin
							l_q   <= satf(acc_nx);
							acc_q <= '0;
						end else if (op_q - OP_ORT == 6'd3) begin
							r_q   <= satf(acc_nx);
							acc_q <= AW'(dl_q);
						end
					end else begin
						if (op_q - OP_WET == 6'd1) begin
							odata_q[SB-1:0] <= satf(acc_nx);
							acc_q           <= AW'(dr_q);
						end else if (op_q - OP_WET == 6'd3) begin
							odata_q[2*SB-1:SB] <= satf(acc_nx);
							state_q            <= ST_OUT;
						end
					end
				end
				ST_MWR: begin
					if (op_q < OP_TAP) begin
						state_q <= ST_MRD;
					end else begin
						pos_q[wln] <= nxt(pos_q[wln], len_e[wln]);
						op_q <= op_q + 1'b1;
						if (op_q + 1'b1 == OP_ORT) state_q <= ST_MUL;
					end
				end
				ST_MRD: state_q <= ST_MRDW;
				ST_MRDW: state_q <= ST_MRDL;
				ST_MRDL: begin
					if (op_q < OP_TAP) begin
						r_q        <= mrd_q;
						pos_q[stg] <= nxt(pos_q[stg], len_e[stg]);
						op_q       <= op_q + 2'd2;
						state_q    <= (op_q + 2'd2 == OP_TAP) ? ST_MRD : ST_MUL;
					end else begin
						tap_q   <= mrd_q;
						op_q    <= op_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// dry samples kept for the wet/dry mix
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			dl_q <= s_tdata[SB-1:0];
			dr_q <= s_tdata[2*SB-1:SB];
		end
	end
endmodule

// ===== src/rdnr_check.sv =====
// ----------------------------------------------------------------------------
// rdnr_check: port-level checks of the reverb top level
// Handshake and sequencing properties, bound to the top level.
// ----------------------------------------------------------------------------
module rdnr_check #(
	parameter int unsigned SAMPLE_BITS = rdnr_pkg::SAMPLE_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [2*SAMPLE_BITS-1:0] m_tdata
);
	// a result held back stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one transaction at a time: no intake while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while result pending");

	// after an intake the block is busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready after intake");

	// no result directly after an intake
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result too early");
endmodule

bind rotation_delay_network_reverb_top rdnr_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
